[design/hswt_pkg.sv]
// Shared types, constants and helpers of the hourly schedule wake timer.
package hswt_pkg;

    // Time and schedule constants
    localparam int          TIME_W          = 40;
    localparam int          WAIT_W          = 17;
    localparam int          HOURS_PER_DAY   = 24;
    localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
    localparam logic [16:0] EMPTY_MASK_WAIT = 17'd3600;
    localparam logic [4:0]  LAST_HOUR       = 5'd23;
    // Five folds bring any 33-bit value below 2071
    localparam int          FOLD_STEPS      = 5;

    // Register reset values
    localparam logic [23:0] HOUR_MASK_RST   = 24'hFF_FFFF;
    localparam logic [7:0]  ZONE_OFFSET_RST = 8'd0;
    localparam logic [39:0] MIN_VALID_RST   = 40'd1577836800;

    // Register indexes on the configuration port (byte address / 8)
    typedef enum logic [1:0] {
        REG_HOUR_MASK   = 2'd0,
        REG_ZONE_OFFSET = 2'd1,
        REG_MIN_VALID   = 2'd2
    } t_reg_idx;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_REDUCE,
        ST_SPLIT,
        ST_HOUR,
        ST_SCAN
    } t_state;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [23:0] hour_mask;
        logic [7:0]  zone_offset_hours;
        logic [39:0] min_valid_time;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic fold_step;
        logic reduce_step;
        logic split_step;
        logic hour_step;
        logic scan_step;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic found;
        logic mask_empty;
    } t_dp_stat;

    // Remainder modulo 24 of a value below 512: split into 8*a + b, fold a mod 3
    function automatic logic [4:0] mod24(input logic [8:0] v);
        logic [5:0]  a;
        logic [12:0] p;
        logic [4:0]  q;
        logic [5:0]  diff;
        a    = v[8:3];
        p    = 13'(a) * 13'd43;
        q    = p[11:7];
        diff = a - (6'(q) * 6'd3);
        return {diff[1:0], v[2:0]};
    endfunction

endpackage

[design/hswt_regs.sv]
// Configuration register file on the APB-style port.
module hswt_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output hswt_pkg::t_cfg      o_cfg
);

    logic [23:0] r_hour_mask;
    logic [7:0]  r_zone_offset;
    logic [39:0] r_min_valid;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:3];

    // Write a register on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_mask   <= hswt_pkg::HOUR_MASK_RST;
            r_zone_offset <= hswt_pkg::ZONE_OFFSET_RST;
            r_min_valid   <= hswt_pkg::MIN_VALID_RST;
        end else if (wr_en) begin
            case (reg_idx)
                hswt_pkg::REG_HOUR_MASK:   r_hour_mask   <= pwdata[23:0];
                hswt_pkg::REG_ZONE_OFFSET: r_zone_offset <= pwdata[7:0];
                hswt_pkg::REG_MIN_VALID:   r_min_valid   <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            hswt_pkg::REG_HOUR_MASK:   prdata = {40'd0, r_hour_mask};
            hswt_pkg::REG_ZONE_OFFSET: prdata = {56'd0, r_zone_offset};
            hswt_pkg::REG_MIN_VALID:   prdata = {24'd0, r_min_valid};
            default:                   prdata = 64'd0;
        endcase
    end

    assign o_cfg.hour_mask         = r_hour_mask;
    assign o_cfg.zone_offset_hours = r_zone_offset;
    assign o_cfg.min_valid_time    = r_min_valid;

endmodule

[design/hswt_ctrl.sv]
// Controller state machine: sequences fold, reduce, split, hour and scan phases.
module hswt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  hswt_pkg::t_dp_stat   i_stat,
    output hswt_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] LAST_STEP = 3'(hswt_pkg::FOLD_STEPS - 1);

    hswt_pkg::t_state r_state, n_state;
    logic [2:0]       r_step, n_step;
    logic             scan_end;

    assign scan_end = i_stat.found | i_stat.mask_empty;

    // Hold state and fold step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hswt_pkg::ST_IDLE;
            r_step  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            hswt_pkg::ST_IDLE: begin
                n_step = 3'd0;
                if (start) begin
                    n_state = hswt_pkg::ST_FOLD;
                end
            end
            hswt_pkg::ST_FOLD: begin
                n_step = r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    n_state = hswt_pkg::ST_REDUCE;
                end
            end
            hswt_pkg::ST_REDUCE: begin
                n_state = hswt_pkg::ST_SPLIT;
            end
            hswt_pkg::ST_SPLIT: begin
                n_state = hswt_pkg::ST_HOUR;
            end
            hswt_pkg::ST_HOUR: begin
                n_state = hswt_pkg::ST_SCAN;
            end
            hswt_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = hswt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hswt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            hswt_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            hswt_pkg::ST_FOLD:   o_cmd.fold_step   = 1'b1;
            hswt_pkg::ST_REDUCE: o_cmd.reduce_step = 1'b1;
            hswt_pkg::ST_SPLIT:  o_cmd.split_step  = 1'b1;
            hswt_pkg::ST_HOUR:   o_cmd.hour_step   = 1'b1;
            hswt_pkg::ST_SCAN: begin
                o_cmd.finish    = scan_end;
                o_cmd.scan_step = ~scan_end;
            end
            default: busy = 1'b0;
        endcase
    end

    // Fold phase never overruns its step count
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hswt_pkg::ST_FOLD) |-> (r_step <= LAST_STEP))
        else $error("fold step count out of range");

    // Last fold step always hands over to the reduce phase
    a_fold_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hswt_pkg::ST_FOLD && r_step == LAST_STEP) |=>
        (r_state == hswt_pkg::ST_REDUCE))
        else $error("fold phase did not end");

    // Only one command active at a time
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("conflicting datapath commands");

endmodule

[design/hswt_dp.sv]
// Datapath: time of day by folding mod 86400, hour split, forward hour scan, result register.
module hswt_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [39:0]          i_utc_seconds,
    input  hswt_pkg::t_cfg       i_cfg,
    input  hswt_pkg::t_dp_cmd    i_cmd,
    output hswt_pkg::t_dp_stat   o_stat,
    output logic                 o_valid,
    output logic                 o_refresh_now,
    output logic [16:0]          o_wait_seconds
);

    // One day is 128 * 675: the low 7 bits pass through, the rest is reduced mod 675.
    // 2^11 mod 675 is 23, so bits above bit 10 fold down with weight 23.
    localparam logic [4:0]  FOLD_WEIGHT = 5'd23;
    localparam logic [11:0] MOD_1X      = 12'd675;
    localparam logic [11:0] MOD_2X      = 12'd1350;
    localparam logic [11:0] MOD_3X      = 12'd2025;
    // ceil(2^27 / 3600): exact hour quotient for every second of one day
    localparam logic [15:0] HOUR_RECIP  = 16'd37283;

    logic [32:0] r_acc;
    logic [6:0]  r_lo;
    logic [16:0] r_day;
    logic [4:0]  r_qmod;
    logic        r_stale;
    logic        r_refresh;
    logic [4:0]  r_h;
    logic [16:0] r_wait_acc;
    logic        r_valid;
    logic        r_refresh_out;
    logic [16:0] r_wait_out;

    logic [26:0] fold_sum;
    logic [11:0] fold_val;
    logic [9:0]  mod_val;
    logic [32:0] recip_prod;
    logic [16:0] hour_end;
    logic [16:0] first_wait;
    logic [8:0]  off_biased;
    logic [4:0]  off_mod;
    logic [5:0]  hour_sum;
    logic [4:0]  hour;
    logic [4:0]  h_first;
    logic [4:0]  h_inc;

    // Fold the high bits down, reduce below 675, split the day into hour and seconds
    always_comb begin
        fold_sum = 27'(r_acc[10:0]) + 27'(r_acc[32:11]) * 27'(FOLD_WEIGHT);
        fold_val = r_acc[11:0];
        if (fold_val >= MOD_3X) begin
            mod_val = 10'(fold_val - MOD_3X);
        end else if (fold_val >= MOD_2X) begin
            mod_val = 10'(fold_val - MOD_2X);
        end else if (fold_val >= MOD_1X) begin
            mod_val = 10'(fold_val - MOD_1X);
        end else begin
            mod_val = fold_val[9:0];
        end
        recip_prod = 33'(r_day) * 33'(HOUR_RECIP);
        hour_end   = 17'(r_qmod + 5'd1) * 17'(hswt_pkg::SECS_PER_HOUR);
        first_wait = hour_end - r_day;
    end

    // Local hour from UTC hour of day and the zone offset folded to 0..23
    always_comb begin
        off_biased = {i_cfg.zone_offset_hours[7], i_cfg.zone_offset_hours} + 9'd144;
        off_mod    = hswt_pkg::mod24(off_biased);
        hour_sum   = 6'(r_qmod) + 6'(off_mod);
        hour       = (hour_sum >= 6'(hswt_pkg::HOURS_PER_DAY))
                   ? 5'(hour_sum - 6'(hswt_pkg::HOURS_PER_DAY)) : hour_sum[4:0];
        h_first    = (hour == hswt_pkg::LAST_HOUR) ? 5'd0 : hour + 5'd1;
        h_inc      = (r_h == hswt_pkg::LAST_HOUR) ? 5'd0 : r_h + 5'd1;
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc   <= i_utc_seconds[39:7];
            r_lo    <= i_utc_seconds[6:0];
            r_stale <= (i_utc_seconds < i_cfg.min_valid_time);
        end
        if (i_cmd.fold_step) begin
            r_acc <= 33'(fold_sum);
        end
        if (i_cmd.reduce_step) begin
            r_day <= {mod_val, r_lo};
        end
        if (i_cmd.split_step) begin
            r_qmod <= recip_prod[31:27];
        end
        if (i_cmd.hour_step) begin
            r_refresh  <= r_stale | i_cfg.hour_mask[hour];
            r_h        <= h_first;
            r_wait_acc <= first_wait;
        end
        if (i_cmd.scan_step) begin
            r_h        <= h_inc;
            r_wait_acc <= r_wait_acc + 17'(hswt_pkg::SECS_PER_HOUR);
        end
        if (i_cmd.finish) begin
            r_refresh_out <= r_refresh;
            r_wait_out    <= o_stat.mask_empty ? hswt_pkg::EMPTY_MASK_WAIT : r_wait_acc;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_stat.found      = i_cfg.hour_mask[r_h];
    assign o_stat.mask_empty = (i_cfg.hour_mask == 24'd0);

    assign o_valid        = r_valid;
    assign o_refresh_now  = r_refresh_out;
    assign o_wait_seconds = r_wait_out;

endmodule

[design/hourly_schedule_wake_timer.sv]
// Top level of the hourly schedule wake timer: register file, controller, datapath.
//
//  Channel   Handshake                      Payload
//  -------   ----------------------------   ------------------------------
//  input     start & !busy                  i_utc_seconds[39:0]
//  result    o_valid (one-cycle strobe)     o_refresh_now, o_wait_seconds[16:0]
//  config    psel & penable & pwrite        paddr[4:3] index, pwdata[63:0]
//
//  An item passes from acceptance through the fold steps, the reduce step, the hour split,
//  the hour step, the scan and the result register; the scan steps forward k hours (1..24)
//  to reach the next enabled hour, and an empty mask ends it on its first step. busy is
//  high from acceptance until the strobe cycle, in which a new beat may already be accepted.
//  Reset is synchronous and active low; the configuration registers return to their reset
//  values. o_valid is high for one cycle only; o_refresh_now and o_wait_seconds then hold.
module hourly_schedule_wake_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [39:0] i_utc_seconds,
    output logic        o_valid,
    output logic        o_refresh_now,
    output logic [16:0] o_wait_seconds,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    hswt_pkg::t_cfg     cfg;
    hswt_pkg::t_dp_cmd  dp_cmd;
    hswt_pkg::t_dp_stat dp_stat;

    hswt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hswt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    hswt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_utc_seconds  (i_utc_seconds),
        .i_cfg          (cfg),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_valid        (o_valid),
        .o_refresh_now  (o_refresh_now),
        .o_wait_seconds (o_wait_seconds)
    );

    // Accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // A result only follows work in progress
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without work");

    // Wait lies within one day
    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_wait_seconds >= 17'd1 && o_wait_seconds <= 17'd86400))
        else $error("wait out of range");

    // Empty mask gives one hour of wait
    a_empty_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg.hour_mask == 24'd0) |-> (o_wait_seconds == 17'd3600))
        else $error("empty mask wait wrong");

endmodule

[sim/hswt_wake_checker.sv]
`timescale 1ns / 1ps
// Scoreboard of the hourly schedule wake timer: predicts each wake decision and checks it.
module hswt_wake_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [39:0] i_utc_seconds,
    input  logic        i_valid,
    input  logic        i_refresh_now,
    input  logic [16:0] i_wait_seconds,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_in_flight
);

    // One predicted wake decision, with the time that caused it
    typedef struct packed {
        logic [39:0] utc;
        logic        refresh;
        logic [16:0] sleep_secs;
    } t_wake;

    logic [23:0] hour_mask_q;
    logic [7:0]  zone_offset_q;
    logic [39:0] min_valid_q;
    t_wake       wake_due_q[$];
    int          fails = 0;

    assign o_fail_count = fails;

    // Local hour, stale check and forward search for the next enabled hour
    function automatic t_wake predict_wake(input logic [39:0] utc);
        t_wake       w;
        int          zone;
        int          zone_mod;
        int          hour;
        int          h;
        int unsigned to_next;
        w.utc    = utc;
        zone     = int'($signed(zone_offset_q));
        zone_mod = zone % hswt_pkg::HOURS_PER_DAY;
        if (zone_mod < 0) begin
            zone_mod += hswt_pkg::HOURS_PER_DAY;
        end
        hour = int'((utc / hswt_pkg::SECS_PER_HOUR) % hswt_pkg::HOURS_PER_DAY);
        hour = (hour + zone_mod) % hswt_pkg::HOURS_PER_DAY;
        w.refresh    = (utc < min_valid_q) ? 1'b1 : hour_mask_q[hour];
        w.sleep_secs = hswt_pkg::EMPTY_MASK_WAIT;
        if (hour_mask_q != '0) begin
            to_next = int'(hswt_pkg::SECS_PER_HOUR) - int'(utc % hswt_pkg::SECS_PER_HOUR);
            for (int ahead = 1; ahead <= hswt_pkg::HOURS_PER_DAY; ahead++) begin
                h = (hour + ahead) % hswt_pkg::HOURS_PER_DAY;
                if (hour_mask_q[h]) begin
                    w.sleep_secs = 17'(to_next + (ahead - 1) * int'(hswt_pkg::SECS_PER_HOUR));
                    break;
                end
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_wake due;
        if (!i_rst_n) begin
            hour_mask_q   = hswt_pkg::HOUR_MASK_RST;
            zone_offset_q = hswt_pkg::ZONE_OFFSET_RST;
            min_valid_q   = hswt_pkg::MIN_VALID_RST;
            wake_due_q.delete();
        end else begin
            // Check a result beat against the oldest prediction
            if (i_valid) begin
                if (wake_due_q.size() == 0) begin
                    fails++;
                    $display("%0t: result beat with no item in flight (refresh %0d, wait %0d)",
                             $time, i_refresh_now, i_wait_seconds);
                end else begin
                    due = wake_due_q.pop_front();
                    if (i_refresh_now !== due.refresh) begin
                        fails++;
                        $display("%0t: utc %0d refresh_now expected %0d, got %0d",
                                 $time, due.utc, due.refresh, i_refresh_now);
                    end
                    if (i_wait_seconds !== due.sleep_secs) begin
                        fails++;
                        $display("%0t: utc %0d wait_seconds expected %0d, got %0d",
                                 $time, due.utc, due.sleep_secs, i_wait_seconds);
                    end
                end
            end
            // Predict an accepted input beat with the current settings
            if (i_start && !i_busy) begin
                wake_due_q.push_back(predict_wake(i_utc_seconds));
            end
            // Track register writes; the spare index is ignored
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    hswt_pkg::REG_HOUR_MASK:   hour_mask_q   = i_pwdata[23:0];
                    hswt_pkg::REG_ZONE_OFFSET: zone_offset_q = i_pwdata[7:0];
                    hswt_pkg::REG_MIN_VALID:   min_valid_q   = i_pwdata[39:0];
                    default: ;
                endcase
            end
        end
        o_in_flight <= wake_due_q.size();
    end

endmodule

[sim/hourly_schedule_wake_timer_test.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the hourly schedule wake timer, checked by hswt_wake_checker.
module hourly_schedule_wake_timer_test;

    localparam logic [1:0]  REG_SPARE    = 2'd3;
    localparam logic [39:0] TIME_MAX     = 40'hFF_FFFF_FFFF;
    localparam logic [39:0] DAY_BASE     = 40'd86400 * 40'd20000;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 56;
    localparam int          TAIL_CYCLES  = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [39:0] i_utc_seconds;
    logic        o_valid;
    logic        o_refresh_now;
    logic [16:0] o_wait_seconds;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          in_flight;
    logic [39:0] cur_min_valid;

    // Sender idle percentage of each random phase
    int idle_pct_of[PHASES] = '{0, 70, 0, 9, 70, 0, 9, 70};

    hourly_schedule_wake_timer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_utc_seconds  (i_utc_seconds),
        .o_valid        (o_valid),
        .o_refresh_now  (o_refresh_now),
        .o_wait_seconds (o_wait_seconds),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    hswt_wake_checker wake_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_utc_seconds  (i_utc_seconds),
        .i_valid        (o_valid),
        .i_refresh_now  (o_refresh_now),
        .i_wait_seconds (o_wait_seconds),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_in_flight    (in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("hourly_schedule_wake_timer_test: done, errors");
        $finish;
    end

    // Drive one time beat, hold until accepted, then by chance of idle_pct idle for a random gap
    task automatic send_time(input logic [39:0] utc, input int idle_pct);
        start         <= 1'b1;
        i_utc_seconds <= utc;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Setup and access cycle of one register write
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == hswt_pkg::REG_MIN_VALID) begin
            cur_min_valid = value[39:0];
        end
    endtask

    // Hold until every accepted beat has produced its result
    task automatic wait_drained();
        do @(posedge i_clk); while (in_flight != 0);
    endtask

    // Mix of full-range times, hour edges, stale-edge times and realistic clocks
    function automatic logic [39:0] random_utc(input logic [39:0] min_valid);
        logic [39:0] t;
        int          delta;
        case ($urandom_range(3))
            0: t = {8'($urandom), 32'($urandom)};
            1: begin
                t = 40'($urandom_range(305_000_000)) * 40'(hswt_pkg::SECS_PER_HOUR);
                case ($urandom_range(3))
                    0: ;
                    1: t += 40'd1;
                    2: t += 40'd3599;
                    default: t += 40'($urandom_range(3599));
                endcase
            end
            2: begin
                delta = $urandom_range(4);
                if (min_valid < 40'd2) begin
                    t = 40'(delta);
                end else if (min_valid > TIME_MAX - 40'd2) begin
                    t = TIME_MAX - 40'(delta);
                end else begin
                    t = min_valid - 40'd2 + 40'(delta);
                end
            end
            default: t = 40'($urandom_range(2_100_000_000, 1_500_000_000));
        endcase
        return t;
    endfunction

    initial begin
        logic [63:0] val;
        start         <= 1'b0;
        i_utc_seconds <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        cur_min_valid = hswt_pkg::MIN_VALID_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: time extremes, hour edges, stale edge
        send_time(40'd0, 0);
        send_time(TIME_MAX, 0);
        send_time(40'd3599, 0);
        send_time(40'd3600, 0);
        send_time(40'd86399, 0);
        send_time(hswt_pkg::MIN_VALID_RST - 40'd1, 0);
        send_time(hswt_pkg::MIN_VALID_RST, 0);
        start <= 1'b0;
        wait_drained();

        // Empty mask, with and without a stale clock
        write_reg(hswt_pkg::REG_HOUR_MASK, 64'h0);
        send_time(40'd1_700_000_000, 0);
        send_time(40'd5, 0);
        start <= 1'b0;
        wait_drained();

        // Only hour 0 enabled: full-day wrap, and one second before it
        write_reg(hswt_pkg::REG_MIN_VALID, 64'h0);
        write_reg(hswt_pkg::REG_HOUR_MASK, 64'h1);
        send_time(DAY_BASE, 0);
        send_time(DAY_BASE + 40'd5, 0);
        send_time(DAY_BASE - 40'd1, 0);
        start <= 1'b0;
        wait_drained();

        // Offset extremes
        write_reg(hswt_pkg::REG_HOUR_MASK, 64'h0F_0F0F);
        write_reg(hswt_pkg::REG_ZONE_OFFSET, 64'h80);
        send_time(DAY_BASE + 40'd7200, 0);
        send_time(DAY_BASE + 40'd60_000, 0);
        start <= 1'b0;
        wait_drained();
        write_reg(hswt_pkg::REG_ZONE_OFFSET, 64'h7F);
        send_time(DAY_BASE + 40'd7200, 0);
        send_time(DAY_BASE + 40'd60_000, 0);
        start <= 1'b0;
        wait_drained();

        // Everything stale, last hour only; spare index must change nothing
        write_reg(hswt_pkg::REG_MIN_VALID, {24'h0, TIME_MAX});
        write_reg(hswt_pkg::REG_HOUR_MASK, 64'h80_0000);
        send_time(TIME_MAX - 40'd1, 0);
        send_time(40'd12345, 0);
        start <= 1'b0;
        wait_drained();
        write_reg(REG_SPARE, {$urandom, $urandom});
        send_time(DAY_BASE + 40'd3000, 0);
        send_time(TIME_MAX, 0);
        start <= 1'b0;
        wait_drained();

        // Random phases, each with fresh settings and its own idle rate
        for (int ph = 0; ph < PHASES; ph++) begin
            val = {$urandom, $urandom};
            case ($urandom_range(4))
                0: val[23:0] = 24'hFF_FFFF;
                1: val[23:0] = 24'h0;
                2: val[23:0] = 24'h1 << $urandom_range(23);
                3: val[23:0] = (24'h1 << $urandom_range(23)) | (24'h1 << $urandom_range(23));
                default: val[23:0] = 24'($urandom);
            endcase
            write_reg(hswt_pkg::REG_HOUR_MASK, val);
            val = {$urandom, $urandom};
            case ($urandom_range(2))
                0: val[7:0] = 8'h80;
                1: val[7:0] = 8'h7F;
                default: ;
            endcase
            write_reg(hswt_pkg::REG_ZONE_OFFSET, val);
            val = {$urandom, $urandom};
            case ($urandom_range(3))
                0: val[39:0] = '0;
                1: val[39:0] = TIME_MAX;
                2: val[39:0] = 40'($urandom_range(2_100_000_000, 1_500_000_000));
                default: ;
            endcase
            write_reg(hswt_pkg::REG_MIN_VALID, val);
            if ($urandom_range(3) == 0) begin
                write_reg(REG_SPARE, {$urandom, $urandom});
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_time(random_utc(cur_min_valid), idle_pct_of[ph]);
            end
            start <= 1'b0;
            wait_drained();
        end

        // Let any stray beat show up, then judge
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && in_flight == 0) begin
            $display("hourly_schedule_wake_timer_test: done, clean");
        end else begin
            $display("hourly_schedule_wake_timer_test: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
design/hswt_pkg.sv
design/hswt_regs.sv
design/hswt_ctrl.sv
design/hswt_dp.sv
design/hourly_schedule_wake_timer.sv
sim/hswt_wake_checker.sv
sim/hourly_schedule_wake_timer_test.sv
